FILE: hdl/olcv_pkg.sv
// Package for the location code validator.
// Holds the character classes, digit table, limits and the verdict type.
// Depends on nothing; used by every module in hdl/.
package olcv_pkg;

    localparam int unsigned POS_W        = 5;
    localparam int unsigned FULL_SEP_POS = 8;
    localparam int unsigned DIGIT_BASE   = 20;
    localparam int unsigned LAT_LIMIT     = 90;
    localparam int unsigned LON_LIMIT     = 180;
    localparam int unsigned NUM_DIGITS    = 20;
    localparam int unsigned DIGIT_W       = 5;

    // Smallest digit value whose scaled value reaches twice the limit.
    localparam int unsigned LAT_DIGIT_MIN =
        (2 * LAT_LIMIT + DIGIT_BASE - 1) / DIGIT_BASE;
    localparam int unsigned LON_DIGIT_MIN =
        (2 * LON_LIMIT + DIGIT_BASE - 1) / DIGIT_BASE;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    localparam logic [7:0] DIGIT_SET [NUM_DIGITS] = '{
        8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h43, 8'h46,
        8'h47, 8'h48, 8'h4A, 8'h4D, 8'h50, 8'h51, 8'h52, 8'h56, 8'h57, 8'h58
    };

    // Classification of one upper-cased character.
    typedef struct packed {
        logic               is_digit;
        logic [DIGIT_W-1:0] digit;
        logic               is_plus;
        logic               is_zero;
    } olcv_class_t;

    // One result request.
    typedef struct packed {
        logic code_full;
        logic code_short;
        logic code_valid;
    } olcv_verdict_t;

    // Digit value of a character, NUM_DIGITS when it is not a digit.
    function automatic logic [DIGIT_W-1:0] digit_value(input logic [7:0] c);
        logic [DIGIT_W-1:0] v;
        v = DIGIT_W'(NUM_DIGITS);
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (DIGIT_SET[i] == c) begin
                v = DIGIT_W'(i);
            end
        end
        return v;
    endfunction

endpackage

FILE: hdl/location_code_validator.sv
// Top level of the location code validator.
// Instantiates olcv_char_class and olcv_track; uses olcv_pkg.
//
// The block takes the characters of one location code, one request per
// cycle on the s_ channel while s_tready is high, with s_tlast set on the
// final character; a new character can follow in the very next cycle
// unless the input stalls. Only the final character of a code produces a
// result request, which appears on the m_ channel in the cycle after that
// final character is accepted and holds
// there until m_tready takes it. The result says whether the code is valid,
// whether it is a short code (separator before position eight) and whether
// it is a full code (separator at eight and both leading digits in range).
// Characters are classified case-insensitively; the running state is cleared
// after every final character, so codes may be streamed back to back. The
// input stalls whenever a finished result is still waiting and m_tready is
// low, whatever the next character is; one register stage separates the
// two channels.
module location_code_validator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic       s_tlast,   // is_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] code_valid, [1] code_short, [2] code_full, rest zero
);
    import olcv_pkg::*;

    olcv_class_t   cls;
    olcv_verdict_t verdict;
    olcv_verdict_t out_data_reg;
    logic          out_valid_reg;
    logic          accept;

    // Accept whenever the output register is empty or is being emptied now.
    assign s_tready = ~out_valid_reg | m_tready;
    assign accept   = s_tvalid & s_tready;

    olcv_char_class u_class (
        .ch  (s_tdata),
        .cls (cls)
    );

    olcv_track u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .is_last (s_tlast),
        .cls     (cls),
        .verdict (verdict)
    );

    // Output register: loaded by the final character of a code.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept && s_tlast) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_tlast) begin
            out_data_reg <= verdict;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_data_reg.code_full, out_data_reg.code_short,
                       out_data_reg.code_valid};

`ifndef ASSERT_OFF
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tlast |=> m_tvalid)
        else $error("final character produced no result");
    a_drain_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !(accept && s_tlast) |=> !m_tvalid)
        else $error("result repeated after it was taken");
    a_short_is_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1] || m_tdata[2]) |-> m_tdata[0] && !(m_tdata[1] && m_tdata[2]))
        else $error("short or full flag on an invalid code");
`endif

endmodule

FILE: hdl/olcv_char_class.sv
// Character classifier for the location code validator.
// Folds case and looks the character up in the digit table; uses olcv_pkg.
module olcv_char_class (
    input  logic [7:0]           ch,
    output olcv_pkg::olcv_class_t cls
);
    import olcv_pkg::*;

    logic [7:0]         upper;
    logic [DIGIT_W-1:0] dval;

    always_comb begin
        if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
            upper = ch - CASE_OFFSET;
        end else begin
            upper = ch;
        end
        dval         = digit_value(upper);
        cls.digit    = dval;
        cls.is_digit = (dval != DIGIT_W'(NUM_DIGITS));
        cls.is_plus  = (upper == CHAR_PLUS);
        cls.is_zero  = (upper == CHAR_ZERO);
    end

endmodule

FILE: hdl/olcv_track.sv
// Running code state and end-of-code verdict for the location code validator.
// Holds the flags and saturating counters; uses olcv_pkg.
module olcv_track (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    accept,
    input  logic                    is_last,
    input  olcv_pkg::olcv_class_t   cls,
    output olcv_pkg::olcv_verdict_t verdict
);
    import olcv_pkg::*;

    logic [POS_W-1:0] position_reg, position_next;
    logic             bad_char_reg, bad_char_next;
    logic [1:0]       sep_count_reg, sep_count_next;
    logic [POS_W-1:0] sep_index_reg, sep_index_next;
    logic [1:0]       after_sep_reg, after_sep_next;
    logic             pad_started_reg, pad_started_next;
    logic             pad_error_reg, pad_error_next;
    logic             pad_odd_reg, pad_odd_next;
    logic             pad_closed_reg, pad_closed_next;
    logic             lat_bad_reg, lat_bad_next;
    logic             lon_bad_reg, lon_bad_next;
    logic             valid_c;
    logic             short_c;

    always_comb begin
        bad_char_next    = bad_char_reg | ~(cls.is_digit | cls.is_plus | cls.is_zero);
        after_sep_next   = after_sep_reg;
        sep_count_next   = sep_count_reg;
        sep_index_next   = sep_index_reg;
        pad_started_next = pad_started_reg;
        pad_error_next   = pad_error_reg;
        pad_odd_next     = pad_odd_reg;
        pad_closed_next  = pad_closed_reg;
        lat_bad_next     = lat_bad_reg;
        lon_bad_next     = lon_bad_reg;

        if (sep_count_reg != 2'd0 && after_sep_reg != 2'd2) begin
            after_sep_next = after_sep_reg + 2'd1;
        end
        if (cls.is_plus) begin
            if (sep_count_reg == 2'd0) begin
                sep_index_next = position_reg;
            end
            if (sep_count_reg != 2'd2) begin
                sep_count_next = sep_count_reg + 2'd1;
            end
        end
        if (cls.is_zero) begin
            if (position_reg == '0 || pad_closed_reg) begin
                pad_error_next = 1'b1;
            end
            pad_started_next = 1'b1;
            pad_odd_next     = ~pad_odd_reg;
        end else if (pad_started_reg) begin
            pad_closed_next = 1'b1;
        end
        if (position_reg == POS_W'(0)) begin
            if (cls.is_digit && cls.digit >= DIGIT_W'(LAT_DIGIT_MIN)) begin
                lat_bad_next = 1'b1;
            end
        end else if (position_reg == POS_W'(1)) begin
            if (cls.is_digit && cls.digit >= DIGIT_W'(LON_DIGIT_MIN)) begin
                lon_bad_next = 1'b1;
            end
        end
        if (position_reg != POS_MAX) begin
            position_next = position_reg + POS_W'(1);
        end else begin
            position_next = position_reg;
        end

        valid_c = ~bad_char_next
                & (sep_count_next == 2'd1)
                & (sep_index_next <= POS_W'(FULL_SEP_POS))
                & ~sep_index_next[0]
                & (after_sep_next != 2'd1)
                & ~(pad_started_next & (pad_error_next | pad_odd_next | ~cls.is_plus));
        short_c = valid_c & (sep_index_next < POS_W'(FULL_SEP_POS));

        verdict.code_valid = valid_c;
        verdict.code_short = short_c;
        verdict.code_full  = valid_c & ~short_c & ~lat_bad_next & ~lon_bad_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && is_last)) begin
            position_reg    <= '0;
            bad_char_reg    <= 1'b0;
            sep_count_reg   <= 2'd0;
            sep_index_reg   <= '0;
            after_sep_reg   <= 2'd0;
            pad_started_reg <= 1'b0;
            pad_error_reg   <= 1'b0;
            pad_odd_reg     <= 1'b0;
            pad_closed_reg  <= 1'b0;
            lat_bad_reg     <= 1'b0;
            lon_bad_reg     <= 1'b0;
        end else if (accept) begin
            position_reg    <= position_next;
            bad_char_reg    <= bad_char_next;
            sep_count_reg   <= sep_count_next;
            sep_index_reg   <= sep_index_next;
            after_sep_reg   <= after_sep_next;
            pad_started_reg <= pad_started_next;
            pad_error_reg   <= pad_error_next;
            pad_odd_reg     <= pad_odd_next;
            pad_closed_reg  <= pad_closed_next;
            lat_bad_reg     <= lat_bad_next;
            lon_bad_reg     <= lon_bad_next;
        end
    end

`ifndef ASSERT_OFF
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_last |=> position_reg == '0 && sep_count_reg == 2'd0)
        else $error("state not cleared after last character");
    a_sep_count_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        sep_count_reg != 2'd3)
        else $error("separator count passed saturation");
    a_after_needs_sep: assert property (@(posedge aclk) disable iff (!aresetn)
        after_sep_reg != 2'd0 |-> sep_count_reg != 2'd0)
        else $error("characters counted after a missing separator");
`endif

endmodule

FILE: tb/location_code_validator_tb.sv
// Self-checking testbench for location_code_validator.
// Streams location codes one character per request and checks each verdict
// against an in-bench tracker; depends on olcv_pkg for the verdict type only.
module location_code_validator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import olcv_pkg::olcv_verdict_t;

    // Character constants and the rules of the code format.
    localparam logic [7:0] PLUS_CH   = 8'h2B;
    localparam logic [7:0] ZERO_CH   = 8'h30;
    localparam logic [7:0] LOWER_A   = 8'h61;
    localparam logic [7:0] LOWER_Z   = 8'h7A;
    localparam logic [7:0] UPPER_A   = 8'h41;
    localparam logic [7:0] CASE_GAP  = 8'h20;
    localparam int         NUM_DIG   = 20;
    localparam int         DIG_STEP  = 20;
    localparam int         LAT_LIMIT = 90;
    localparam int         LON_LIMIT = 180;
    localparam int         SEP_FULL  = 8;
    localparam int         POS_SAT   = 31;

    // Digit alphabet in value order.
    localparam logic [7:0] DIGIT_CHARS [NUM_DIG] = '{
        "2", "3", "4", "5", "6", "7", "8", "9", "C", "F",
        "G", "H", "J", "M", "P", "Q", "R", "V", "W", "X"
    };

    // One character waiting to be sent. A set hold flag makes the sender wait
    // until every verdict already owed has been taken before sending it.
    typedef struct {
        logic [7:0] ch;
        logic       last;
        bit         hold;
    } char_req_t;

    // Running state of the code being tracked.
    typedef struct {
        int unsigned pos;
        int unsigned seps;
        int unsigned sep_at;
        int unsigned after_sep;
        bit          bad_char;
        bit          pad_on;
        bit          pad_err;
        bit          pad_odd;
        bit          pad_closed;
        bit          lat_bad;
        bit          lon_bad;
    } code_tracker_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] ch
    logic       s_tlast  = 1'b0;    // is_last
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [0] code_valid, [1] code_short, [2] code_full

    char_req_t     pending_chars[$];
    olcv_verdict_t owed_verdicts[$];
    code_tracker_t trk = '{default: 0};
    int            mismatch_count = 0;

    // Sender burst shaping and receiver stall pattern.
    int burst_left = 1;
    int gap_left   = 0;
    int stall_mode = 0;
    int stall_left = 0;

    location_code_validator u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Value of a digit character, NUM_DIG when it is not in the alphabet.
    function automatic int digit_index(input logic [7:0] c);
        for (int i = 0; i < NUM_DIG; i++) begin
            if (DIGIT_CHARS[i] == c) begin
                return i;
            end
        end
        return NUM_DIG;
    endfunction

    // Folds one accepted character into the tracker. On the final character it
    // returns 1 with the verdict the block must produce, and clears the state.
    function automatic bit track_char(input logic [7:0] raw, input logic last,
                                      output olcv_verdict_t verdict);
        logic [7:0] c;
        int         d;
        bit         ok;
        c = (raw >= LOWER_A && raw <= LOWER_Z) ? raw - CASE_GAP : raw;
        d = digit_index(c);
        verdict = '0;
        if (d == NUM_DIG && c != PLUS_CH && c != ZERO_CH) begin
            trk.bad_char = 1'b1;
        end
        // The counter after the separator moves before the separator itself
        // is counted, so the separator character is never counted in it.
        if (trk.seps >= 1 && trk.after_sep < 2) begin
            trk.after_sep++;
        end
        if (c == PLUS_CH) begin
            if (trk.seps == 0) begin
                trk.sep_at = trk.pos;
            end
            if (trk.seps < 2) begin
                trk.seps++;
            end
        end
        if (c == ZERO_CH) begin
            if (trk.pos == 0 || trk.pad_closed) begin
                trk.pad_err = 1'b1;
            end
            trk.pad_on  = 1'b1;
            trk.pad_odd = !trk.pad_odd;
        end else if (trk.pad_on) begin
            trk.pad_closed = 1'b1;
        end
        // Characters outside the digit alphabet never fail the range checks.
        if (trk.pos == 0 && d < NUM_DIG && d * DIG_STEP >= 2 * LAT_LIMIT) begin
            trk.lat_bad = 1'b1;
        end else if (trk.pos == 1 && d < NUM_DIG && d * DIG_STEP >= 2 * LON_LIMIT) begin
            trk.lon_bad = 1'b1;
        end
        if (trk.pos < POS_SAT) begin
            trk.pos++;
        end
        if (!last) begin
            return 1'b0;
        end
        ok = !trk.bad_char && trk.seps == 1 && trk.sep_at <= SEP_FULL
             && trk.sep_at[0] == 1'b0 && trk.after_sep != 1;
        // Padding is only legal as one even run that does not start the code, in a
        // code whose final character is a separator.
        if (trk.pad_on && (trk.pad_err || trk.pad_odd || c != PLUS_CH)) begin
            ok = 1'b0;
        end
        verdict.code_valid = ok;
        verdict.code_short = ok && trk.sep_at < SEP_FULL;
        verdict.code_full  = ok && !verdict.code_short && !trk.lat_bad && !trk.lon_bad;
        trk = '{default: 0};
        return 1'b1;
    endfunction

    // A random digit, upper- or lower-case.
    function automatic logic [7:0] pick_digit();
        logic [7:0] c;
        c = DIGIT_CHARS[$urandom_range(0, NUM_DIG - 1)];
        if (c >= UPPER_A && $urandom_range(0, 3) == 0) begin
            c = c + CASE_GAP;
        end
        return c;
    endfunction

    // Any byte at all, weighted toward the characters the format knows.
    function automatic logic [7:0] pick_noise();
        case ($urandom_range(0, 5))
            0, 1:    return 8'($urandom_range(0, 255));
            2, 3:    return pick_digit();
            4:       return PLUS_CH;
            default: return ZERO_CH;
        endcase
    endfunction

    // Queues one code; the final character carries the last flag.
    task automatic queue_code(input logic [7:0] cs[$], input bit hold);
        foreach (cs[i]) begin
            pending_chars.push_back('{ch: cs[i], last: (i == cs.size() - 1),
                                      hold: hold && (i == 0)});
        end
    endtask

    task automatic queue_text(input string s, input bit hold);
        logic [7:0] cs[$];
        for (int i = 0; i < s.len(); i++) begin
            cs.push_back(s[i]);
        end
        queue_code(cs, hold);
    endtask

    // Builds one random code. Most are well formed, full or short, some with
    // padding, and a quarter of those get one character broken. The rest are
    // noise, a few of them long enough to saturate the position counter.
    task automatic random_code(ref logic [7:0] cs[$]);
        int kind;
        int sep_at;
        int pad_at;
        int tail;
        int len;
        int idx;
        cs.delete();
        kind = $urandom_range(0, 11);
        if (kind <= 8) begin
            sep_at = (kind <= 4) ? SEP_FULL : 2 * $urandom_range(0, 3);
            pad_at = sep_at;
            if (sep_at >= 4 && $urandom_range(0, 2) == 0) begin
                pad_at = 2 * $urandom_range(1, sep_at / 2 - 1);
            end
            for (int i = 0; i < sep_at; i++) begin
                cs.push_back((i < pad_at) ? pick_digit() : ZERO_CH);
            end
            cs.push_back(PLUS_CH);
            if (pad_at == sep_at) begin
                tail = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 7);
                repeat (tail) cs.push_back(pick_digit());
            end
            if ($urandom_range(0, 3) == 0) begin
                idx = $urandom_range(0, cs.size() - 1);
                case ($urandom_range(0, 4))
                    0: cs[idx] = 8'($urandom_range(0, 255));
                    1: cs[idx] = ZERO_CH;
                    2: cs[idx] = PLUS_CH;
                    3: if (cs.size() > 1) cs.delete(idx);
                    default: cs.insert(idx, pick_digit());
                endcase
            end
        end else begin
            len = (kind == 11) ? $urandom_range(28, 40) : $urandom_range(1, 12);
            repeat (len) cs.push_back(pick_noise());
        end
    endtask

    // Sender. Each accepted request is folded into the tracker at the edge
    // that takes it. A new request goes out in bursts of random length with
    // random gaps, and a request marked hold waits until no verdict is owed.
    always @(posedge aclk) begin
        olcv_verdict_t verdict;
        char_req_t     req;
        bit            send;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready && track_char(s_tdata, s_tlast, verdict)) begin
                owed_verdicts.push_back(verdict);
            end
            if (!s_tvalid || s_tready) begin
                send = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_chars.size() > 0) begin
                    send = !(pending_chars[0].hold && owed_verdicts.size() > 0);
                end
                if (send) begin
                    req = pending_chars.pop_front();
                    s_tdata  <= req.ch;
                    s_tlast  <= req.last;
                    s_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Checks each verdict taken against the oldest one owed, then
    // sets m_tready from a pattern that switches between always ready, random
    // and mostly stalled.
    always @(posedge aclk) begin
        olcv_verdict_t got;
        olcv_verdict_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = olcv_verdict_t'(m_tdata[2:0]);
                if (owed_verdicts.size() == 0) begin
                    $error("unexpected verdict request, m_tdata = 0x%02h", m_tdata);
                    mismatch_count++;
                end else begin
                    want = owed_verdicts.pop_front();
                    if (got.code_valid !== want.code_valid) begin
                        $error("code_valid: expected %0d, got %0d",
                               want.code_valid, got.code_valid);
                        mismatch_count++;
                    end
                    if (got.code_short !== want.code_short) begin
                        $error("code_short: expected %0d, got %0d",
                               want.code_short, got.code_short);
                        mismatch_count++;
                    end
                    if (got.code_full !== want.code_full) begin
                        $error("code_full: expected %0d, got %0d",
                               want.code_full, got.code_full);
                        mismatch_count++;
                    end
                    if (m_tdata[7:3] !== 5'd0) begin
                        $error("m_tdata[7:3]: expected 0, got 0x%02h", m_tdata[7:3]);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(20, 80);
            end else begin
                stall_left--;
            end
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        logic [7:0] cs[$];
        int         total_chars;
        int         code_count;
        // Directed codes: a lone separator, a lone high byte, a lone leading
        // zero, lower-case folding, exactly one character after the separator,
        // a short code with padding, and a padded code at the full separator
        // position whose second digit is out of range.
        queue_text("+", 1'b0);
        cs.push_back(8'hFF);
        queue_code(cs, 1'b0);
        queue_text("0", 1'b0);
        queue_text("9c+", 1'b0);
        queue_text("22+X", 1'b0);
        queue_text("2200+", 1'b0);
        queue_text("CX000000+", 1'b1);
        total_chars = pending_chars.size();
        code_count  = 0;
        while (total_chars < 1200) begin
            random_code(cs);
            // Every fortieth code waits for the output to drain first.
            queue_code(cs, (code_count % 40) == 0);
            total_chars += cs.size();
            code_count++;
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        do begin
            @(posedge aclk);
        end while (pending_chars.size() != 0 || s_tvalid || owed_verdicts.size() != 0);
        repeat (16) @(posedge aclk);

        if (owed_verdicts.size() != 0) begin
            $error("%0d verdicts never arrived", owed_verdicts.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("location_code_validator_tb: done, clean");
        end else begin
            $display("location_code_validator_tb: done, errors");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("location_code_validator_tb: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/olcv_pkg.sv
hdl/olcv_char_class.sv
hdl/olcv_track.sv
hdl/location_code_validator.sv
tb/location_code_validator_tb.sv
